FILE: hw/rtl/ordered_list_append_delete_top_macros.svh
// ----------------------------------------------------------------------------
// Ordered list assertion macros
// Shared concurrent assertion forms for the ordered list block.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_APPEND_DELETE_TOP_MACROS_SVH
`define ORDERED_LIST_APPEND_DELETE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: whenever ante holds, cons holds too
`define OLAD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("olad: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons holds in the cycle after
`define OLAD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olad: next-cycle check failed");

`else

`define OLAD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define OLAD_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/olad_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Sizes, request codes and status codes of the ordered list block.
// ----------------------------------------------------------------------------
package olad_pkg;

   // List size and derived widths
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int LEN_W    = 5;

   // Request codes
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

endpackage

FILE: hw/rtl/olad_ram.sv
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module olad_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write on enable
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register read data; hold it when no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hw/rtl/ordered_list_append_delete_top.sv
// ----------------------------------------------------------------------------
// Ordered list top level
// Keeps up to CAPACITY signed values in insertion order; appends at the tail
// and deletes the first equal entry, closing the gap.
// ----------------------------------------------------------------------------
// One request is handled at a time. An append, or a delete on an empty list,
// goes straight to the report state, which registers its result; the next
// request is taken once the result is registered. A delete on a list of n
// entries walks the entry memory one entry per cycle through its single read
// port and then moves every later entry up one place, one per cycle; search
// and move together cover all n positions whether or not a match is found.
// A result waits in the output register until drained, and while a previous
// result still waits there the next result, and the input, wait with it. The
// output register lets a new request be taken while the previous result still
// waits to be drained. After reset the list is empty at once; no clearing pass
// is needed.

`include "ordered_list_append_delete_top_macros.svh"

module ordered_list_append_delete_top
   import olad_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_type,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [LEN_W-1:0]         rsp_length
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_REPORT
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   logic [DATA_W-1:0]       value_ff, value_in;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]        rsp_length_ff, rsp_length_in;

   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr;
   logic [DATA_W-1:0]       ram_wdata;
   logic                    ram_re;
   logic [IDX_W-1:0]        ram_raddr;
   logic [DATA_W-1:0]       ram_rdata;

   logic                    is_full;
   logic                    last_entry;
   logic [IDX_W-1:0]        next_ptr;

   // Entry store
   olad_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign last_entry = ((CNT_W'(ptr_ff) + CNT_W'(1)) >= count_ff);
   assign next_ptr   = ptr_ff + IDX_W'(1);

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_length = rsp_length_ff;

   // Sequence requests: read one entry per cycle, compare, move later ones up.
   // A move reads p + 1 while writing p - 1, so read and write never meet.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      ram_we        = 1'b0;
      ram_waddr     = count_ff[IDX_W-1:0];
      ram_wdata     = req_value;
      ram_re        = 1'b0;
      ram_raddr     = next_ptr;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in = req_value;
               if (req_type == OP_APPEND) begin
                  state_in = S_REPORT;
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                     status_in = ST_DONE;
                  end
               end else if (count_ff == '0) begin
                  status_in = ST_EMPTY;
                  state_in  = S_REPORT;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  ptr_in    = '0;
                  state_in  = S_SEARCH;
               end
            end
         end

         S_SEARCH: begin
            if (ram_rdata == value_ff) begin
               if (last_entry) begin
                  count_in  = count_ff - CNT_W'(1);
                  status_in = ST_DONE;
                  state_in  = S_REPORT;
               end else begin
                  ram_re   = 1'b1;
                  ptr_in   = next_ptr;
                  state_in = S_SHIFT;
               end
            end else if (last_entry) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_REPORT;
            end else begin
               ram_re = 1'b1;
               ptr_in = next_ptr;
            end
         end

         S_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff - IDX_W'(1);
            ram_wdata = ram_rdata;
            if (last_entry) begin
               count_in  = count_ff - CNT_W'(1);
               status_in = ST_DONE;
               state_in  = S_REPORT;
            end else begin
               ram_re = 1'b1;
               ptr_in = next_ptr;
            end
         end

         S_REPORT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_length_in = LEN_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, list length and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   // Checks
   `OLAD_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `OLAD_ASSERT_IMP(a_no_rw_collide, clock, reset, ram_we && ram_re, ram_waddr != ram_raddr)
   `OLAD_ASSERT_IMP(a_shift_in_list, clock, reset, state_ff == S_SHIFT,
                    (ptr_ff != '0) && (CNT_W'(ptr_ff) < count_ff))
   `OLAD_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready,
                    state_ff != S_IDLE)

endmodule
